[design/rcd_pkg.sv]
// Shared types, codes and ring index helpers for the restricted circular deque.
`default_nettype none

package rcd_pkg;

  // Ring geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [2:0] req_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] mode_t;

  // Request codes
  localparam req_t REQ_PUSH_BACK  = 3'd0;
  localparam req_t REQ_PUSH_FRONT = 3'd1;
  localparam req_t REQ_POP_FRONT  = 3'd2;
  localparam req_t REQ_POP_BACK   = 3'd3;
  localparam req_t REQ_PEEK       = 3'd4;

  // Status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;
  localparam status_t ST_REFUSED   = 2'd3;

  // Restriction modes
  localparam mode_t MODE_FREE     = 2'd0;
  localparam mode_t MODE_OUT_ONLY = 2'd1;
  localparam mode_t MODE_IN_ONLY  = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOAD
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic exec;
    logic capture;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
  } sts_t;

  function automatic idx_t next_slot(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t prev_slot(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

`default_nettype wire

[design/rcd_if.sv]
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface rcd_in_if;
  logic                 valid;
  logic                 ready;
  rcd_pkg::req_t        req_type;
  rcd_pkg::word_t       push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface rcd_out_if;
  logic                 valid;
  logic                 ready;
  rcd_pkg::word_t       popped_value;
  rcd_pkg::word_t       front_value;
  rcd_pkg::word_t       back_value;
  rcd_pkg::status_t     status;
  logic                 is_empty;
  logic                 is_full;

  modport source (output valid, output popped_value, output front_value,
                  output back_value, output status, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input popped_value, input front_value,
                  input back_value, input status, input is_empty,
                  input is_full, output ready);
endinterface

`default_nettype wire

[design/restricted_circular_deque_core.sv]
// Top level of the restricted circular deque.
// The sequencer takes one request at a time: it steps each accepted request
// through the execute, memory read and result load steps around the
// registered-read slot memory, and the load step waits while a result is unread.
// A result waiting at the output does not block acceptance of the next request.
// Reset (rst_n low, synchronous) empties the deque and clears the mode to
// unrestricted; slot contents are left as they are.
`default_nettype none

module restricted_circular_deque_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire rcd_pkg::mode_t  cfg_wdata,
  rcd_in_if.sink               in_ch,
  rcd_out_if.source            out_ch
);
  import rcd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  rcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcd_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_ch.req_type),
    .in_push_value    (in_ch.push_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_popped_value (out_ch.popped_value),
    .out_front_value  (out_ch.front_value),
    .out_back_value   (out_ch.back_value),
    .out_status       (out_ch.status),
    .out_is_empty     (out_ch.is_empty),
    .out_is_full      (out_ch.is_full)
  );

endmodule

`default_nettype wire

[design/rcd_ram.sv]
// Generic RAM: one write port, two registered read ports.
`default_nettype none

module rcd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_a,
  output logic      [WIDTH-1:0]                 rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_b,
  output logic      [WIDTH-1:0]                 rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[design/rcd_ctrl.sv]
// Sequencer that steps one request through execute, read and load.
`default_nettype none

module rcd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire rcd_pkg::sts_t sts,
  output rcd_pkg::cmd_t      cmd
);
  import rcd_pkg::*;

  state_t state_r, state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_READ;
      S_READ: state_nxt = S_LOAD;
      S_LOAD: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_EXEC: cmd.exec = 1'b1;
      S_READ: cmd.capture = 1'b1;
      S_LOAD: cmd.load_out = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

  // Checks
  a_exec_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> cmd.capture) else $error("execute not followed by read");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.out_busy) else $error("result loaded over a waiting one");
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_req |=> cmd.exec) else $error("accepted item not executed");

endmodule

`default_nettype wire

[design/rcd_datapath.sv]
// Deque indices, slot memory, mode register and result register.
`default_nettype none

module rcd_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire rcd_pkg::mode_t     cfg_wdata,
  input  wire rcd_pkg::req_t      in_req_type,
  input  wire rcd_pkg::word_t     in_push_value,
  input  wire rcd_pkg::cmd_t      cmd,
  output rcd_pkg::sts_t           sts,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output rcd_pkg::word_t          out_popped_value,
  output rcd_pkg::word_t          out_front_value,
  output rcd_pkg::word_t          out_back_value,
  output rcd_pkg::status_t        out_status,
  output logic                    out_is_empty,
  output logic                    out_is_full
);
  import rcd_pkg::*;

  mode_t   mode_r;
  req_t    req_r;
  word_t   word_r;
  idx_t    front_r, front_nxt;
  idx_t    back_r, back_nxt;
  logic    empty_r, empty_nxt;
  status_t status_r, status_nxt;
  logic    pop_ok_r, pop_ok_nxt;
  word_t   popped_r;
  logic    out_valid_r;

  logic    is_push, is_pop, refused, full;
  logic    we;
  idx_t    waddr, pop_addr, raddr_a;
  logic [WORD_W-1:0] rdata_a, rdata_b;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FREE;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r  <= in_req_type;
      word_r <= in_push_value;
    end
  end

  // Decide the request against current state
  always_comb begin
    is_push  = (req_r == REQ_PUSH_BACK) || (req_r == REQ_PUSH_FRONT);
    is_pop   = (req_r == REQ_POP_FRONT) || (req_r == REQ_POP_BACK);
    refused  = (req_r > REQ_PEEK)
            || (mode_r == MODE_OUT_ONLY && req_r == REQ_POP_FRONT)
            || (mode_r == MODE_IN_ONLY && req_r == REQ_PUSH_BACK);
    full     = !empty_r && (next_slot(back_r) == front_r);
    pop_addr = (req_r == REQ_POP_FRONT) ? front_r : back_r;

    status_nxt = ST_OK;
    front_nxt  = front_r;
    back_nxt   = back_r;
    empty_nxt  = empty_r;
    pop_ok_nxt = 1'b0;
    we         = 1'b0;
    waddr      = '0;

    if (refused) begin
      status_nxt = ST_REFUSED;
    end else if (is_push) begin
      if (full) begin
        status_nxt = ST_OVERFLOW;
      end else begin
        we = 1'b1;
        if (empty_r) begin
          front_nxt = '0;
          back_nxt  = '0;
          empty_nxt = 1'b0;
          waddr     = '0;
        end else if (req_r == REQ_PUSH_BACK) begin
          back_nxt = next_slot(back_r);
          waddr    = back_nxt;
        end else begin
          front_nxt = prev_slot(front_r);
          waddr     = front_nxt;
        end
      end
    end else if (empty_r) begin
      status_nxt = ST_UNDERFLOW;
    end else if (is_pop) begin
      pop_ok_nxt = 1'b1;
      if (front_r == back_r) begin
        front_nxt = '0;
        back_nxt  = '0;
        empty_nxt = 1'b1;
      end else if (req_r == REQ_POP_FRONT) begin
        front_nxt = next_slot(front_r);
      end else begin
        back_nxt = prev_slot(back_r);
      end
    end
  end

  // Advance indices on execute
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      empty_r <= 1'b1;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      empty_r <= empty_nxt;
    end
  end

  // Hold status and pop flag for the result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
    if (cmd.capture) begin
      popped_r <= pop_ok_r ? word_t'(rdata_a) : '0;
    end
  end

  // Port A reads the popped slot on execute, then the new front
  assign raddr_a = cmd.exec ? pop_addr : front_r;

  rcd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk     (clk),
    .we      (we && cmd.exec),
    .waddr   (waddr),
    .wdata   (word_r),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (back_r),
    .rdata_b (rdata_b)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_popped_value <= popped_r;
      out_front_value  <= empty_r ? '0 : word_t'(rdata_a);
      out_back_value   <= empty_r ? '0 : word_t'(rdata_b);
      out_status       <= status_r;
      out_is_empty     <= empty_r;
      out_is_full      <= !empty_r && (next_slot(back_r) == front_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_busy = out_valid_r && !out_ready;

  // Checks
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (front_r == '0 && back_r == '0)) else $error("empty deque with moved index");
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && is_push && status_nxt == ST_OK |=> !empty_r)
    else $error("successful push left deque empty");
  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && status_nxt == ST_REFUSED |=>
      $stable(front_r) && $stable(back_r) && $stable(empty_r))
    else $error("refused request changed state");

endmodule

`default_nettype wire
